@@ rtl/core/vertex_matrix_transform_macros.svh @@
// assertion macros shared by the vertex transform checker
// no dependencies; included by files that hold concurrent assertions
`ifndef VERTEX_MATRIX_TRANSFORM_MACROS_SVH
`define VERTEX_MATRIX_TRANSFORM_MACROS_SVH

// same-cycle implication, disabled while in reset
`define VMT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define VMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/vmt_pkg.sv @@
// types and constants of the vertex matrix transform
// no dependencies; imported by vmt_column, vertex_matrix_transform and the testbench
`timescale 1ns / 1ps

package vmt_pkg;

    localparam int NUM_COMP    = 4;
    localparam int FRAC_SHIFT  = 12;
    localparam int SLOT_BITS   = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_0 = 2'd0,
        REG_ROW_1 = 2'd1,
        REG_ROW_2 = 2'd2,
        REG_ROW_3 = 2'd3
    } vmt_reg_idx_t;

    // identity matrix, 1.0 in Q4.12 on the diagonal
    localparam logic [NUM_COMP-1:0][CFG_DATA_W-1:0] ROW_RESET = {
        64'h1000_0000_0000_0000,
        64'h0000_1000_0000_0000,
        64'h0000_0000_1000_0000,
        64'h0000_0000_0000_1000
    };

    // per-stage load enables handed to the column datapaths
    typedef struct packed {
        logic ld_mul;
        logic ld_add;
        logic ld_out;
    } vmt_stage_ctl_t;

endpackage

@@ rtl/core/vmt_if.sv @@
// valid/ready stream interfaces for vertices in and transformed vertices out
// depends on nothing; used by vertex_matrix_transform
`timescale 1ns / 1ps

interface vmt_in_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;
    logic signed [COORD_WIDTH-1:0] in_w;

    modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                    input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                    output ready);
endinterface

interface vmt_out_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic signed [COORD_WIDTH-1:0] out_w;
    logic                          saturated;

    modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                    output saturated, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                    input saturated, output ready);
endinterface

@@ rtl/core/vmt_column.sv @@
// one output column: four products, adder tree, floor shift and saturation
// depends on vmt_pkg; instantiated four times by vertex_matrix_transform
`timescale 1ns / 1ps

module vmt_column
    import vmt_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                          clk,
    input  vmt_stage_ctl_t                ctl,
    input  logic signed [COORD_WIDTH-1:0] vin  [NUM_COMP],
    input  logic signed [COEF_WIDTH-1:0]  coef [NUM_COMP],
    output logic signed [COORD_WIDTH-1:0] res,
    output logic                          sat
);

    localparam int PROD_W = COORD_WIDTH + COEF_WIDTH;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int HI_W   = SUM_W - COORD_WIDTH + 1;

    localparam logic signed [COORD_WIDTH-1:0] MAX_CODE = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] MIN_CODE = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [PROD_W-1:0]      prod_reg [NUM_COMP];
    logic signed [PAIR_W-1:0]      pair_lo_reg;
    logic signed [PAIR_W-1:0]      pair_hi_reg;
    logic signed [SUM_W-1:0]       sum;
    logic signed [SUM_W-1:0]       quot;
    logic        [HI_W-1:0]        quot_hi;
    logic                          ovf;
    logic signed [COORD_WIDTH-1:0] res_next;
    logic signed [COORD_WIDTH-1:0] res_reg;
    logic                          sat_reg;

    // stage 1: products
    always_ff @(posedge clk)
    begin
        if (ctl.ld_mul)
        begin
            for (int r = 0; r < NUM_COMP; r++)
            begin
                prod_reg[r] <= PROD_W'(vin[r] * coef[r]);
            end
        end
    end

    // stage 2: pairwise sums
    always_ff @(posedge clk)
    begin
        if (ctl.ld_add)
        begin
            pair_lo_reg <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
            pair_hi_reg <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
        end
    end

    // stage 3: final sum, floor by the fraction shift, clip to the coordinate range
    always_comb
    begin
        sum     = SUM_W'(pair_lo_reg) + SUM_W'(pair_hi_reg);
        quot    = sum >>> FRAC_SHIFT;
        quot_hi = quot[SUM_W-1:COORD_WIDTH-1];
        ovf     = !((&quot_hi) || !(|quot_hi));
        if (!ovf)
        begin
            res_next = quot[COORD_WIDTH-1:0];
        end
        else if (quot[SUM_W-1])
        begin
            res_next = MIN_CODE;
        end
        else
        begin
            res_next = MAX_CODE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_out)
        begin
            res_reg <= res_next;
            sat_reg <= ovf;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

@@ rtl/core/vertex_matrix_transform.sv @@
// top level of the vertex matrix transform: matrix registers, stage control, four columns
// depends on vmt_pkg, vmt_in_if, vmt_out_if and vmt_column
`timescale 1ns / 1ps

// Transforms one homogeneous vertex (x, y, z, w) per clock by a 4x4 matrix, row-vector
// convention: out[c] = sum over r of in[r] * M[r][c]. Coordinates are signed Q16.16 (at
// COORD_WIDTH 32), coefficients signed Q4.12 in the low COEF_WIDTH bits of each 16-bit
// slot of the row registers. Each full sum is floored by 12 bits and clipped to the
// coordinate range; saturated flags any clipped component. The matrix resets to
// identity. A vertex passes three register stages (multiply, pair add, final add with
// clip) and its result is valid once it sits in the last of them. Each stage holds one
// vertex and moves on whenever the stage after it can load, so one vertex is accepted
// per clock while the result side takes every result; the longest path is the 32x16
// multiplier per product in the first stage. Stalls on the result side back up
// through the stages without loss; ready upstream is low only when all three are full
// and the result is not taken. Matrix writes are meant to happen while no vertex is in
// flight.

module vertex_matrix_transform
    import vmt_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    vmt_in_if.sink                 vertex,
    vmt_out_if.source              result,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    // matrix rows, one 64-bit register each
    logic [NUM_COMP-1:0][CFG_DATA_W-1:0] row_reg;

    // valid bits of the three stages
    logic v_mul_reg, v_add_reg, v_out_reg;
    logic v_mul_next, v_add_next, v_out_next;

    // a stage may load when it is empty or its content moves on this cycle
    logic rdy_mul, rdy_add, rdy_out;

    vmt_stage_ctl_t ctl;

    logic signed [COORD_WIDTH-1:0] vin [NUM_COMP];
    logic signed [COORD_WIDTH-1:0] col_res [NUM_COMP];
    logic        [NUM_COMP-1:0]    col_sat;

    // matrix register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= ROW_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_ROW_0: row_reg[0] <= wr_data;
                REG_ROW_1: row_reg[1] <= wr_data;
                REG_ROW_2: row_reg[2] <= wr_data;
                REG_ROW_3: row_reg[3] <= wr_data;
            endcase
        end
    end

    // stall chain from the result side back to the vertex side
    always_comb
    begin
        rdy_out    = !v_out_reg || result.ready;
        rdy_add    = !v_add_reg || rdy_out;
        rdy_mul    = !v_mul_reg || rdy_add;

        v_mul_next = rdy_mul ? vertex.valid : v_mul_reg;
        v_add_next = rdy_add ? v_mul_reg    : v_add_reg;
        v_out_next = rdy_out ? v_add_reg    : v_out_reg;

        // only move payload when a live vertex enters the stage
        ctl.ld_mul = rdy_mul && vertex.valid;
        ctl.ld_add = rdy_add && v_mul_reg;
        ctl.ld_out = rdy_out && v_add_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_mul_reg <= 1'b0;
            v_add_reg <= 1'b0;
            v_out_reg <= 1'b0;
        end
        else
        begin
            v_mul_reg <= v_mul_next;
            v_add_reg <= v_add_next;
            v_out_reg <= v_out_next;
        end
    end

    assign vertex.ready = rdy_mul;

    assign vin[0] = vertex.in_x;
    assign vin[1] = vertex.in_y;
    assign vin[2] = vertex.in_z;
    assign vin[3] = vertex.in_w;

    // one datapath per output component; column c takes entry c of every row
    for (genvar c = 0; c < NUM_COMP; c++)
    begin : g_col
        logic signed [COEF_WIDTH-1:0] coef [NUM_COMP];

        for (genvar r = 0; r < NUM_COMP; r++)
        begin : g_coef
            // upper slot bits beyond the coefficient width are ignored
            assign coef[r] = row_reg[r][SLOT_BITS*c +: COEF_WIDTH];
        end

        vmt_column #(
            .COORD_WIDTH (COORD_WIDTH),
            .COEF_WIDTH  (COEF_WIDTH)
        ) u_column (
            .clk  (clk),
            .ctl  (ctl),
            .vin  (vin),
            .coef (coef),
            .res  (col_res[c]),
            .sat  (col_sat[c])
        );
    end

    // the last stage doubles as the output register
    assign result.valid     = v_out_reg;
    assign result.out_x     = col_res[0];
    assign result.out_y     = col_res[1];
    assign result.out_z     = col_res[2];
    assign result.out_w     = col_res[3];
    assign result.saturated = |col_sat;

endmodule

@@ rtl/core/vmt_checker.sv @@
// port-level assertions for the vertex matrix transform, bound to the top level
// depends on vertex_matrix_transform_macros.svh and vertex_matrix_transform
`timescale 1ns / 1ps
`include "vertex_matrix_transform_macros.svh"

module vmt_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [COORD_WIDTH-1:0] out_x,
    input logic signed [COORD_WIDTH-1:0] out_y,
    input logic signed [COORD_WIDTH-1:0] out_z,
    input logic signed [COORD_WIDTH-1:0] out_w,
    input logic                          saturated
);

    localparam logic signed [COORD_WIDTH-1:0] MAX_CODE = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] MIN_CODE = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic in_xfer;
    logic any_clip;

    assign in_xfer  = in_valid && in_ready;
    assign any_clip = (out_x == MAX_CODE) || (out_x == MIN_CODE)
                   || (out_y == MAX_CODE) || (out_y == MIN_CODE)
                   || (out_z == MAX_CODE) || (out_z == MIN_CODE)
                   || (out_w == MAX_CODE) || (out_w == MIN_CODE);

    // a result waiting for transfer holds its payload
    `VMT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_x, out_y, out_z, out_w, saturated}), "result changed while stalled")

    // with an empty output stage the pipeline cannot be full
    `VMT_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "vertex side stalled with empty output")

    // a transferred vertex reaches the output when the result side keeps taking
    `VMT_ASSERT_NEXT(a_latency, clk, rst_n, in_xfer ##1 out_ready ##1 out_ready, out_valid, "vertex lost in pipeline")

    // the saturation flag implies a component sits at a range limit
    `VMT_ASSERT_NOW(a_sat_clip, clk, rst_n, out_valid && saturated, any_clip, "saturated without clipped component")

endmodule

bind vertex_matrix_transform vmt_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_vmt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vertex.valid),
    .in_ready  (vertex.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_x     (result.out_x),
    .out_y     (result.out_y),
    .out_z     (result.out_z),
    .out_w     (result.out_w),
    .saturated (result.saturated)
);

@@ tb/tb_vertex_matrix_transform.sv @@
// testbench for vertex_matrix_transform: directed and random vertex streams checked
// against a fixed-point matrix predictor; depends on vertex_matrix_transform, vmt_pkg, vmt_in_if, vmt_out_if
`timescale 1ns / 1ps

module tb_vertex_matrix_transform;
    import vmt_pkg::*;

    localparam int COORD_W      = 32;
    localparam int COEF_W       = 16;
    // three register stages from transfer in to result valid
    localparam int DRAIN_CYCLES = 6;
    // worst case is far below this: ~450 items, each with long gaps on both sides
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_PRINTS   = 40;

    localparam logic signed [COORD_W-1:0] MAXC = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] MINC = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] ONE  = 32'sh0001_0000;

    // identity matrix rows, 1.0 in q4.12 on the diagonal
    localparam logic [CFG_DATA_W-1:0] ID_ROW0 = 64'h0000_0000_0000_1000;
    localparam logic [CFG_DATA_W-1:0] ID_ROW1 = 64'h0000_0000_1000_0000;
    localparam logic [CFG_DATA_W-1:0] ID_ROW2 = 64'h0000_1000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] ID_ROW3 = 64'h1000_0000_0000_0000;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] w;
    } vertex_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] w;
        logic                      saturated;
    } transformed_t;

    logic                   clk;
    logic                   rst_n;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;

    vmt_in_if  #(.COORD_WIDTH(COORD_W)) vertex_bus ();
    vmt_out_if #(.COORD_WIDTH(COORD_W)) result_bus ();

    vertex_matrix_transform #(
        .COORD_WIDTH(COORD_W),
        .COEF_WIDTH (COEF_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .vertex  (vertex_bus),
        .result  (result_bus),
        .wr_en   (wr_en),
        .wr_index(wr_index),
        .wr_data (wr_data)
    );

    // tb copy of the matrix, kept in step with every register write
    logic [CFG_DATA_W-1:0] matrix_rows [NUM_COMP];

    // transformed vertices still owed by the block, oldest first
    transformed_t pending_results [$];

    int unsigned err_count      = 0;
    int unsigned sent_count     = 0;
    int unsigned checked_count  = 0;
    int unsigned clipped_count  = 0;
    int unsigned load_count     = 0;
    int unsigned in_stall_count = 0;
    int unsigned cycle_count    = 0;

    // idle controls shared between the test tasks and the receiver process
    bit          tx_idle_on    = 1'b0;
    bit          rx_idle_on    = 1'b0;
    int unsigned rx_hold_left  = 0;
    int unsigned rx_stall_left = 0;

    // clock and run limit
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                 pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // gap lengths: mostly none or short, now and then a long one
    function automatic int unsigned pick_gap(bit enabled);
        int unsigned roll;
        if (!enabled)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // row-vector times matrix, each column sum floored by 12 bits then clipped
    function automatic transformed_t transform_vertex(vertex_t v);
        longint                   comp_in  [NUM_COMP];
        longint                   comp_out [NUM_COMP];
        longint                   acc;
        longint                   lim_hi;
        longint                   lim_lo;
        logic signed [COEF_W-1:0] coef;
        transformed_t             t;
        int                       r;
        int                       c;
        lim_hi = (longint'(1) <<< (COORD_W - 1)) - 1;
        lim_lo = -lim_hi - 1;
        comp_in[0] = longint'(v.x);
        comp_in[1] = longint'(v.y);
        comp_in[2] = longint'(v.z);
        comp_in[3] = longint'(v.w);
        t.saturated = 1'b0;
        for (c = 0; c < NUM_COMP; c++)
        begin
            acc = 0;
            for (r = 0; r < NUM_COMP; r++)
            begin
                // slot bits above the coefficient width are dropped
                coef = matrix_rows[r][SLOT_BITS*c +: COEF_W];
                acc += comp_in[r] * longint'(coef);
            end
            // arithmetic shift floors toward minus infinity
            acc = acc >>> FRAC_SHIFT;
            if (acc > lim_hi)
            begin
                acc = lim_hi;
                t.saturated = 1'b1;
            end
            else if (acc < lim_lo)
            begin
                acc = lim_lo;
                t.saturated = 1'b1;
            end
            comp_out[c] = acc;
        end
        t.x = comp_out[0][COORD_W-1:0];
        t.y = comp_out[1][COORD_W-1:0];
        t.z = comp_out[2][COORD_W-1:0];
        t.w = comp_out[3][COORD_W-1:0];
        return t;
    endfunction

    function automatic logic signed [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            7:          return ONE;
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       return MAXC;
                    1:       return MINC;
                    2:       return '0;
                    default: return -1;
                endcase
            end
            default:    return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic vertex_t random_vertex();
        vertex_t v;
        v.x = random_coord();
        v.y = random_coord();
        v.z = random_coord();
        // w is usually 1.0 in a real vertex stream
        v.w = ($urandom_range(0, 1) != 0) ? ONE : random_coord();
        return v;
    endfunction

    // either fully random bits or coefficients within about +-1.5
    function automatic logic [CFG_DATA_W-1:0] random_row();
        logic [CFG_DATA_W-1:0] row;
        int                    slot;
        if ($urandom_range(0, 2) == 0)
        begin
            row = {$urandom, $urandom};
        end
        else
        begin
            for (slot = 0; slot < NUM_COMP; slot++)
                row[SLOT_BITS*slot +: SLOT_BITS] = 16'($urandom_range(0, 16'h3000)) - 16'h1800;
        end
        return row;
    endfunction

    task automatic flag_mismatch(string field, logic [COORD_W-1:0] got,
                                 logic [COORD_W-1:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("[%0t] result %0d %s: got %h, want %h", $time, checked_count, field,
                     got, want);
    endtask

    // offers one vertex after a random gap and waits for its transfer;
    // valid stays up afterwards so back-to-back items never toggle it in one step
    task automatic send_vertex(vertex_t v);
        int unsigned gap;
        gap = pick_gap(tx_idle_on);
        if (gap > 0)
        begin
            @(negedge clk);
            vertex_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        vertex_bus.valid <= 1'b1;
        vertex_bus.in_x  <= v.x;
        vertex_bus.in_y  <= v.y;
        vertex_bus.in_z  <= v.z;
        vertex_bus.in_w  <= v.w;
        do
            @(posedge clk);
        while (!vertex_bus.ready);
        pending_results.push_back(transform_vertex(v));
        sent_count++;
    endtask

    // stop offering, then wait until every owed result has come out
    task automatic wait_idle();
        @(negedge clk);
        vertex_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_row(vmt_reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        matrix_rows[idx] = value;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // only ever called with the pipeline drained
    task automatic load_matrix(logic [CFG_DATA_W-1:0] r0, logic [CFG_DATA_W-1:0] r1,
                               logic [CFG_DATA_W-1:0] r2, logic [CFG_DATA_W-1:0] r3);
        write_row(REG_ROW_0, r0);
        write_row(REG_ROW_1, r1);
        write_row(REG_ROW_2, r2);
        write_row(REG_ROW_3, r3);
        load_count++;
    endtask

    // result checker, also counts cycles where the block refuses an offered vertex
    always @(posedge clk)
    begin
        transformed_t want;
        if (rst_n && vertex_bus.valid && !vertex_bus.ready)
            in_stall_count++;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                flag_mismatch("unexpected result", result_bus.out_x, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_bus.out_x !== want.x)
                    flag_mismatch("out_x", result_bus.out_x, want.x);
                if (result_bus.out_y !== want.y)
                    flag_mismatch("out_y", result_bus.out_y, want.y);
                if (result_bus.out_z !== want.z)
                    flag_mismatch("out_z", result_bus.out_z, want.z);
                if (result_bus.out_w !== want.w)
                    flag_mismatch("out_w", result_bus.out_w, want.w);
                if (result_bus.saturated !== want.saturated)
                    flag_mismatch("saturated", COORD_W'(result_bus.saturated),
                                  COORD_W'(want.saturated));
                if (want.saturated)
                    clipped_count++;
            end
            checked_count++;
        end
    end

    // receiver: a forced hold-off first, then random stalls when enabled
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                result_bus.ready <= 1'b0;
                rx_hold_left--;
            end
            else if (rx_stall_left > 0)
            begin
                result_bus.ready <= 1'b0;
                rx_stall_left--;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                rx_stall_left = pick_gap(rx_idle_on);
            end
        end
    end

    // identity after reset passes every vertex through unchanged, no clipping
    task automatic test_identity_after_reset();
        send_vertex('{'0, '0, '0, '0});
        send_vertex('{MAXC, MINC, -1, ONE});
        send_vertex('{MINC, MAXC, ONE, -1});
        send_vertex('{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_8000, 32'sh7FFF_0000});
        send_vertex('{32'sh0000_0001, -2, 32'shFFFF_0000, 32'sh0123_4567});
        wait_idle();
    endtask

    // largest positive and negative coefficients drive every column into both clips
    task automatic test_saturation();
        load_matrix(64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
                    64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF);
        send_vertex('{MAXC, MAXC, MAXC, MAXC});
        send_vertex('{MINC, MINC, MINC, MINC});
        wait_idle();
        load_matrix(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                    64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000);
        send_vertex('{MINC, MINC, MINC, MINC});
        send_vertex('{MAXC, MAXC, MAXC, MAXC});
        wait_idle();
    endtask

    // tiny and negative diagonal entries: negative sums must round down, not toward zero
    task automatic test_floor_rounding();
        load_matrix(64'h0000_0000_0000_0001, 64'h0000_0000_FFFF_0000,
                    64'h0000_F000_0000_0000, 64'h0001_0000_0000_0000);
        send_vertex('{-1, 32'sh0000_0001, 32'sh0000_0FFF, -4096});
        send_vertex('{32'sh0000_1000, -4097, '0, MINC});
        wait_idle();
    endtask

    // translation in the last row, applied through w
    task automatic test_translation();
        load_matrix(ID_ROW0, ID_ROW1, ID_ROW2, 64'h1000_0800_F800_7FFF);
        send_vertex('{32'sh0003_0000, -32'sh0002_8000, '0, ONE});
        send_vertex('{MAXC, MINC, 32'sh0000_0001, ONE});
        wait_idle();
    endtask

    // receiver holds off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        load_matrix(random_row(), random_row(), random_row(), random_row());
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        rx_hold_left = 40;
        repeat (30) send_vertex(random_vertex());
        wait_idle();
    endtask

    // several matrix settings with random vertices, idling switched per phase
    task automatic test_random_phases();
        int phase;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: load_matrix('1, '1, '1, '1);
                1: load_matrix('0, '0, '0, '0);
                2: load_matrix(64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_8000_7FFF,
                               64'h7FFF_7FFF_8000_8000, 64'h8000_8000_7FFF_7FFF);
                default: load_matrix(random_row(), random_row(), random_row(), random_row());
            endcase
            // leave some phases free of idling on one side
            tx_idle_on = (phase % 3) != 1;
            rx_idle_on = (phase % 3) != 2;
            repeat (50) send_vertex(random_vertex());
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        wr_en            = 1'b0;
        wr_index         = '0;
        wr_data          = '0;
        vertex_bus.valid = 1'b0;
        vertex_bus.in_x  = '0;
        vertex_bus.in_y  = '0;
        vertex_bus.in_z  = '0;
        vertex_bus.in_w  = '0;
        matrix_rows[0]   = ID_ROW0;
        matrix_rows[1]   = ID_ROW1;
        matrix_rows[2]   = ID_ROW2;
        matrix_rows[3]   = ID_ROW3;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // the directed tests before the backpressure test run with idling on both sides
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_identity_after_reset();
        test_saturation();
        test_floor_rounding();
        test_translation();
        test_backpressure();
        test_random_phases();

        if (pending_results.size() != 0)
        begin
            err_count += pending_results.size();
            $display("%0d results never arrived", pending_results.size());
        end
        $display("covered %0d vertices over %0d matrix loads, %0d results clipped",
                 sent_count, load_count, clipped_count);
        $display("input held off for %0d cycles by backpressure, %0d field errors",
                 in_stall_count, err_count);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/vmt_pkg.sv
rtl/core/vmt_if.sv
rtl/core/vmt_column.sv
rtl/core/vertex_matrix_transform.sv
rtl/core/vmt_checker.sv
tb/tb_vertex_matrix_transform.sv
